FILE: hw/rtl/sseg_pkg.sv
// shared types and constants for the sine segment drive sequencer
// item structs, operation and sync codes, quarter-wave cosine table
// no dependencies
package sseg_pkg;

    typedef struct packed {
        logic [1:0] op;
        logic       ac_wanted;
        logic [6:0] power_percent;
    } in_item_t;

    typedef struct packed {
        logic       drive_write;
        logic [6:0] drive_level;
        logic [1:0] sync_pulse;
        logic       zero_crossing;
        logic       positive_half;
        logic       running;
    } out_item_t;

    // step commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic mul1;
        logic div1;
        logic mul2;
        logic load_out;
    } sseg_cmd_t;

    localparam logic [1:0] OP_SEGMENT  = 2'd0;
    localparam logic [1:0] OP_HALFSTEP = 2'd1;
    localparam logic [1:0] OP_START    = 2'd2;
    localparam logic [1:0] OP_RESET    = 2'd3;

    localparam logic [1:0] SYNC_NONE = 2'd0;
    localparam logic [1:0] SYNC_ON   = 2'd1;
    localparam logic [1:0] SYNC_OFF  = 2'd2;

    localparam int         CFG_IDX_W       = 2;
    localparam logic [1:0] CFG_FIRST_STEP  = 2'd0;
    localparam logic [1:0] CFG_SECOND_STEP = 2'd1;
    localparam logic [1:0] CFG_IDLE_DRIVE  = 2'd2;

    localparam logic [6:0] FIRST_STEP_RESET  = 7'd60;
    localparam logic [6:0] SECOND_STEP_RESET = 7'd85;
    localparam logic [6:0] IDLE_DRIVE_RESET  = 7'd10;
    localparam logic [6:0] PCT_FULL          = 7'd100;

    // x / 100 == (x * 5243) >> 19 for x below 43699
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    localparam int ROM_LAST = 16;
    localparam logic [6:0] COSINE_ROM [0:ROM_LAST] = '{
        7'd92, 7'd92, 7'd90, 7'd88, 7'd85, 7'd81, 7'd77, 7'd71, 7'd65,
        7'd58, 7'd51, 7'd43, 7'd35, 7'd27, 7'd18, 7'd9, 7'd0
    };

endpackage

FILE: hw/rtl/sseg_ctrl.sv
// controller for the sine segment drive sequencer
// sequences accept, two multiply/divide rounds and the output load
// depends on sseg_pkg
module sseg_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    output logic              out_valid,
    input  logic              out_stall,
    output sseg_pkg::sseg_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MUL1 = 3'd1;
    localparam logic [2:0] ST_DIV1 = 3'd2;
    localparam logic [2:0] ST_MUL2 = 3'd3;
    localparam logic [2:0] ST_DIV2 = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.accept   = (state_reg == ST_IDLE) && in_valid;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_DIV1;
            end
            ST_DIV1:
            begin
                cmd.div1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_DIV2;
            end
            ST_DIV2:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: hw/rtl/sseg_datapath.sv
// datapath for the sine segment drive sequencer
// waveform state, config registers, table lookup, interpolation and scaling
// depends on sseg_pkg
module sseg_datapath #(
    parameter int TABLE_TOP       = 16,
    parameter int AMPLITUDE_WIDTH = 7
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sseg_pkg::sseg_cmd_t                cmd,
    input  sseg_pkg::in_item_t                 in_item,
    input  logic                               cfg_we,
    input  logic [sseg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [6:0]                         cfg_data,
    output sseg_pkg::out_item_t                out_item
);

    localparam int IDX_W = $clog2(TABLE_TOP + 1);
    localparam logic [IDX_W-1:0] TOP_IDX = IDX_W'(TABLE_TOP);
    localparam int LIM_INT = (AMPLITUDE_WIDTH >= 7) ? 127 : ((1 << AMPLITUDE_WIDTH) - 1);
    localparam logic [8:0] LEVEL_LIM = 9'(LIM_INT);

    // table lookup per index, scaled onto the 17-entry table
    logic [6:0] level_tab [TABLE_TOP+1];

    for (genvar i = 0; i <= TABLE_TOP; i++)
    begin : g_tab
        localparam int RAW = (i * sseg_pkg::ROM_LAST) / TABLE_TOP;
        localparam int RI  = (RAW > sseg_pkg::ROM_LAST) ? sseg_pkg::ROM_LAST : RAW;
        assign level_tab[i] = sseg_pkg::COSINE_ROM[RI];
    end

    // config registers
    logic [6:0] first_pct_reg;
    logic [6:0] second_pct_reg;
    logic [6:0] idle_drive_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_pct_reg  <= sseg_pkg::FIRST_STEP_RESET;
            second_pct_reg <= sseg_pkg::SECOND_STEP_RESET;
            idle_drive_reg <= sseg_pkg::IDLE_DRIVE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sseg_pkg::CFG_FIRST_STEP:  first_pct_reg  <= cfg_data;
                sseg_pkg::CFG_SECOND_STEP: second_pct_reg <= cfg_data;
                sseg_pkg::CFG_IDLE_DRIVE:  idle_drive_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // waveform state
    logic [IDX_W-1:0] wave_reg;
    logic [IDX_W-1:0] wave_next;
    logic [IDX_W-1:0] prior_reg;
    logic [IDX_W-1:0] prior_next;
    logic             rising_reg;
    logic             rising_next;
    logic             positive_reg;
    logic             positive_next;
    logic             ac_on_reg;
    logic             ac_on_next;
    logic [1:0]       hsl_reg;
    logic [1:0]       hsl_next;

    // per-item context
    logic             dw_reg;
    logic             dw_next;
    logic             idle_sel_reg;
    logic             idle_sel_next;
    logic [1:0]       sync_reg;
    logic [1:0]       sync_next;
    logic             zc_reg;
    logic             zc_next;
    logic [6:0]       pct_reg;
    logic [6:0]       pct_next;
    logic [6:0]       power_reg;

    logic [IDX_W-1:0] step_idx;

    always_comb
    begin
        wave_next     = wave_reg;
        prior_next    = prior_reg;
        rising_next   = rising_reg;
        positive_next = positive_reg;
        ac_on_next    = ac_on_reg;
        hsl_next      = hsl_reg;
        dw_next       = 1'b0;
        idle_sel_next = 1'b0;
        sync_next     = sseg_pkg::SYNC_NONE;
        zc_next       = 1'b0;
        pct_next      = first_pct_reg;
        step_idx      = wave_reg;
        if (rising_reg)
        begin
            if (wave_reg < TOP_IDX)
            begin
                step_idx = wave_reg + IDX_W'(1);
            end
        end
        else if (wave_reg != '0)
        begin
            step_idx = wave_reg - IDX_W'(1);
        end
        case (in_item.op)
            sseg_pkg::OP_SEGMENT:
            begin
                if (ac_on_reg)
                begin
                    prior_next = wave_reg;
                    wave_next  = step_idx;
                    if (rising_reg)
                    begin
                        if (step_idx >= TOP_IDX)
                        begin
                            rising_next   = 1'b0;
                            positive_next = !positive_reg;
                            zc_next       = 1'b1;
                        end
                    end
                    else if (step_idx == '0)
                    begin
                        rising_next = 1'b1;
                    end
                    dw_next   = 1'b1;
                    sync_next = sseg_pkg::SYNC_ON;
                    hsl_next  = 2'd2;
                    if (rising_reg && (step_idx >= TOP_IDX) && !in_item.ac_wanted)
                    begin
                        ac_on_next    = 1'b0;
                        idle_sel_next = 1'b1;
                    end
                end
            end
            sseg_pkg::OP_HALFSTEP:
            begin
                if (hsl_reg != 2'd0)
                begin
                    if (ac_on_reg)
                    begin
                        sync_next = sseg_pkg::SYNC_OFF;
                        if (hsl_reg == 2'd2)
                        begin
                            dw_next  = 1'b1;
                            pct_next = second_pct_reg;
                        end
                        else if (hsl_reg == 2'd1)
                        begin
                            dw_next  = 1'b1;
                            pct_next = sseg_pkg::PCT_FULL;
                        end
                    end
                    hsl_next = hsl_reg - 2'd1;
                end
            end
            sseg_pkg::OP_START:
            begin
                wave_next     = TOP_IDX;
                hsl_next      = 2'd0;
                positive_next = 1'b1;
                rising_next   = 1'b0;
                ac_on_next    = 1'b1;
            end
            sseg_pkg::OP_RESET:
            begin
                wave_next     = '0;
                positive_next = 1'b1;
                rising_next   = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wave_reg     <= '0;
            prior_reg    <= '0;
            rising_reg   <= 1'b1;
            positive_reg <= 1'b1;
            ac_on_reg    <= 1'b0;
            hsl_reg      <= 2'd0;
        end
        else if (cmd.accept)
        begin
            wave_reg     <= wave_next;
            prior_reg    <= prior_next;
            rising_reg   <= rising_next;
            positive_reg <= positive_next;
            ac_on_reg    <= ac_on_next;
            hsl_reg      <= hsl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            dw_reg       <= dw_next;
            idle_sel_reg <= idle_sel_next;
            sync_reg     <= sync_next;
            zc_reg       <= zc_next;
            pct_reg      <= pct_next;
            power_reg    <= in_item.power_percent;
        end
    end

    // interpolation: a + (b - a) * pct / 100, then * power / 100
    logic [6:0]  tab_a;
    logic [6:0]  tab_b;
    logic [6:0]  diff_mag;
    logic [6:0]  a_reg;
    logic        neg_reg;
    logic [13:0] mag_reg;
    logic [26:0] quo_reg;
    logic [7:0]  quo;
    logic [7:0]  interp;
    logic [14:0] prod2_reg;
    logic [27:0] prod3;
    logic [8:0]  scaled;
    logic [6:0]  level;

    assign tab_a    = level_tab[prior_reg];
    assign tab_b    = level_tab[wave_reg];
    assign diff_mag = (tab_b >= tab_a) ? (tab_b - tab_a) : (tab_a - tab_b);

    assign quo = quo_reg[sseg_pkg::RECIP_SHIFT +: 8];

    always_comb
    begin
        if (neg_reg)
        begin
            interp = ({1'b0, a_reg} >= quo) ? ({1'b0, a_reg} - quo) : 8'd0;
        end
        else
        begin
            interp = {1'b0, a_reg} + quo;
        end
    end

    assign prod3  = {13'd0, prod2_reg} * {15'd0, sseg_pkg::RECIP_100};
    assign scaled = prod3[sseg_pkg::RECIP_SHIFT +: 9];
    assign level  = (scaled > LEVEL_LIM) ? LEVEL_LIM[6:0] : scaled[6:0];

    always_ff @(posedge clk)
    begin
        if (cmd.mul1)
        begin
            a_reg   <= tab_a;
            neg_reg <= (tab_b < tab_a);
            mag_reg <= {7'd0, diff_mag} * {7'd0, pct_reg};
        end
        if (cmd.div1)
        begin
            quo_reg <= {13'd0, mag_reg} * {14'd0, sseg_pkg::RECIP_100};
        end
        if (cmd.mul2)
        begin
            prod2_reg <= {7'd0, interp} * {8'd0, power_reg};
        end
        if (cmd.load_out)
        begin
            out_item.drive_write   <= dw_reg;
            out_item.drive_level   <= !dw_reg ? 7'd0 : (idle_sel_reg ? idle_drive_reg : level);
            out_item.sync_pulse    <= sync_reg;
            out_item.zero_crossing <= zc_reg;
            out_item.positive_half <= positive_reg;
            out_item.running       <= ac_on_reg;
        end
    end

endmodule

FILE: hw/rtl/sine_segment_drive_sequencer.sv
// sine segment drive sequencer, top level
// walks a quarter-wave cosine table and issues a scaled drive level per item
// depends on sseg_pkg, sseg_ctrl, sseg_datapath
//
// input channel: in_valid / in_stall / in_item carry one command item
// (segment tick, half-step tick, start, waveform reset) with ac_wanted and
// power_percent. output channel: out_valid / out_stall / out_item carry
// exactly one result item per input item.
// config channel: cfg_valid / cfg_ready / cfg_index / cfg_data, always
// ready; index 0 first step percent, 1 second step percent, 2 idle drive,
// other indexes are ignored. write only while no item is in flight.
// an accepted item runs through one table lookup and two multiply then
// divide-by-100 rounds on a shared datapath: it steps through the mul1,
// div1 and mul2 states, its result is loaded into the output register from
// the div2 state, and only then does the block take the next item.
// while the receiver stalls, the result holds in the output register; the
// next item is accepted and computed but its load waits for the register.
// reset clears the waveform state, stops generation and restores the
// config registers to 60, 85 and 10.
module sine_segment_drive_sequencer #(
    parameter int TABLE_TOP       = 16,
    parameter int AMPLITUDE_WIDTH = 7
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  sseg_pkg::in_item_t             in_item,
    output logic                           out_valid,
    input  logic                           out_stall,
    output sseg_pkg::out_item_t            out_item,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [sseg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [6:0]                     cfg_data
);

    sseg_pkg::sseg_cmd_t cmd;

    assign cfg_ready = 1'b1;

    sseg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    sseg_datapath #(
        .TABLE_TOP       (TABLE_TOP),
        .AMPLITUDE_WIDTH (AMPLITUDE_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_item   (in_item),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_item  (out_item)
    );

endmodule

FILE: verif/sine_segment_drive_sequencer_tb.sv
// self-checking testbench for sine_segment_drive_sequencer
// a scoreboard class predicts each result item from the accepted input items
// depends on sseg_pkg and the sine_segment_drive_sequencer rtl
module sine_segment_drive_sequencer_tb;

    localparam int TABLE_TOP       = 16;
    localparam int AMPLITUDE_WIDTH = 7;
    localparam logic [sseg_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    class drive_scoreboard;
        logic [6:0] first_pct;
        logic [6:0] second_pct;
        logic [6:0] idle_level;
        logic [4:0] wave_idx;
        logic [4:0] prior_idx;
        logic       rising;
        logic       positive;
        logic       ac_on;
        logic [1:0] half_left;
        sseg_pkg::out_item_t pending_results[$];
        int         errors;

        function new();
            first_pct  = sseg_pkg::FIRST_STEP_RESET;
            second_pct = sseg_pkg::SECOND_STEP_RESET;
            idle_level = sseg_pkg::IDLE_DRIVE_RESET;
            wave_idx   = '0;
            prior_idx  = '0;
            rising     = 1'b1;
            positive   = 1'b1;
            ac_on      = 1'b0;
            half_left  = '0;
            errors     = 0;
        endfunction

        function void set_reg(logic [sseg_pkg::CFG_IDX_W-1:0] idx, logic [6:0] data);
            case (idx)
                sseg_pkg::CFG_FIRST_STEP:  first_pct = data;
                sseg_pkg::CFG_SECOND_STEP: second_pct = data;
                sseg_pkg::CFG_IDLE_DRIVE:  idle_level = data;
                default:         ;
            endcase
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function int cos_at(logic [4:0] idx);
            int r;
            r = int'(idx) * sseg_pkg::ROM_LAST / TABLE_TOP;
            if (r > sseg_pkg::ROM_LAST)
            begin
                r = sseg_pkg::ROM_LAST;
            end
            return int'(sseg_pkg::COSINE_ROM[r]);
        endfunction

        // interpolate between prior and current entry, then scale by power
        function logic [6:0] level_at(int pct, int power);
            int a;
            int b;
            int v;
            int lim;
            a = cos_at(prior_idx);
            b = cos_at(wave_idx);
            v = a + ((b - a) * pct) / 100;
            if (v < 0)
            begin
                v = 0;
            end
            v = (v * power) / 100;
            lim = (1 << AMPLITUDE_WIDTH) - 1;
            if (v > lim)
            begin
                v = lim;
            end
            if (v > 127)
            begin
                v = 127;
            end
            return v[6:0];
        endfunction

        function void note_item(sseg_pkg::in_item_t it);
            sseg_pkg::out_item_t e;
            int        power;
            logic      zc;
            e = '0;
            zc = 1'b0;
            power = int'(it.power_percent);
            case (it.op)
                sseg_pkg::OP_SEGMENT:
                begin
                    if (ac_on)
                    begin
                        prior_idx = wave_idx;
                        if (rising)
                        begin
                            if (wave_idx < TABLE_TOP)
                            begin
                                wave_idx = wave_idx + 5'd1;
                            end
                        end
                        else if (wave_idx > 0)
                        begin
                            wave_idx = wave_idx - 5'd1;
                        end
                        if (rising)
                        begin
                            if (wave_idx >= TABLE_TOP)
                            begin
                                rising = 1'b0;
                                positive = !positive;
                                zc = 1'b1;
                            end
                        end
                        else if (wave_idx == 0)
                        begin
                            rising = 1'b1;
                        end
                        e.drive_write = 1'b1;
                        e.drive_level = level_at(int'(first_pct), power);
                        e.sync_pulse = sseg_pkg::SYNC_ON;
                        half_left = 2'd2;
                        // stop at the zero crossing and park at the idle level
                        if (zc && !it.ac_wanted)
                        begin
                            ac_on = 1'b0;
                            e.drive_level = idle_level;
                        end
                    end
                end
                sseg_pkg::OP_HALFSTEP:
                begin
                    if (half_left > 0)
                    begin
                        if (ac_on)
                        begin
                            e.sync_pulse = sseg_pkg::SYNC_OFF;
                            e.drive_write = 1'b1;
                            if (half_left == 2'd2)
                            begin
                                e.drive_level = level_at(int'(second_pct), power);
                            end
                            else
                            begin
                                e.drive_level = level_at(int'(sseg_pkg::PCT_FULL), power);
                            end
                        end
                        half_left = half_left - 2'd1;
                    end
                end
                sseg_pkg::OP_START:
                begin
                    wave_idx = 5'(TABLE_TOP);
                    half_left = '0;
                    positive = 1'b1;
                    rising = 1'b0;
                    ac_on = 1'b1;
                end
                default:
                begin
                    wave_idx = '0;
                    positive = 1'b1;
                    rising = 1'b1;
                end
            endcase
            e.zero_crossing = zc;
            e.positive_half = positive;
            e.running = ac_on;
            pending_results.push_back(e);
        endfunction

        function void check_field(string name, logic [6:0] want, logic [6:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(sseg_pkg::out_item_t got);
            sseg_pkg::out_item_t e;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with no item waiting, expected none, actual %h",
                         $time, got);
            end
            else
            begin
                e = pending_results.pop_front();
                check_field("drive_write", 7'(e.drive_write), 7'(got.drive_write));
                check_field("drive_level", e.drive_level, got.drive_level);
                check_field("sync_pulse", 7'(e.sync_pulse), 7'(got.sync_pulse));
                check_field("zero_crossing", 7'(e.zero_crossing), 7'(got.zero_crossing));
                check_field("positive_half", 7'(e.positive_half), 7'(got.positive_half));
                check_field("running", 7'(e.running), 7'(got.running));
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    sseg_pkg::in_item_t             in_item = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    sseg_pkg::out_item_t            out_item;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [sseg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [6:0]                     cfg_data = '0;

    drive_scoreboard sb;
    int   active_items = 0;
    int   stall_left = 0;
    logic hold_req = 1'b0;
    logic tx_idle_on = 1'b1;
    logic rx_idle_on = 1'b1;

    sine_segment_drive_sequencer #(
        .TABLE_TOP       (TABLE_TOP),
        .AMPLITUDE_WIDTH (AMPLITUDE_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                sb.note_item(in_item);
            end
            if (out_valid && !out_stall)
            begin
                sb.check_result(out_item);
            end
        end
    end

    // receiver: short random stalls, one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                stall_left = 59;
                out_stall <= 1'b1;
            end
            else if (rx_idle_on && $urandom_range(0, 3) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    function automatic sseg_pkg::in_item_t mk_item(logic [1:0] op, logic wanted,
                                                   logic [6:0] power);
        sseg_pkg::in_item_t it;
        it.op = op;
        it.ac_wanted = wanted;
        it.power_percent = power;
        return it;
    endfunction

    function automatic logic [6:0] rand_power();
        if ($urandom_range(0, 7) == 0)
        begin
            return 7'($urandom_range(101, 127));
        end
        return 7'($urandom_range(0, 100));
    endfunction

    task automatic send_item(sseg_pkg::in_item_t it);
        int gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        if (sb.ac_on || it.op == sseg_pkg::OP_START || it.op == sseg_pkg::OP_RESET)
        begin
            active_items++;
        end
        in_valid <= 1'b1;
        in_item <= it;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic write_reg(logic [sseg_pkg::CFG_IDX_W-1:0] idx, logic [6:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.set_reg(idx, data);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    initial
    begin
        int ph;
        int i;
        int pick;
        int halves;
        int target;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ticks while stopped, start, a full segment, then a reset and a climb to the top
        send_item(mk_item(sseg_pkg::OP_SEGMENT, 1'b1, 7'd100));
        send_item(mk_item(sseg_pkg::OP_HALFSTEP, 1'b0, 7'd100));
        send_item(mk_item(sseg_pkg::OP_START, 1'b0, 7'd0));
        send_item(mk_item(sseg_pkg::OP_SEGMENT, 1'b1, 7'd100));
        send_item(mk_item(sseg_pkg::OP_HALFSTEP, 1'b1, 7'd100));
        send_item(mk_item(sseg_pkg::OP_HALFSTEP, 1'b0, 7'd127));
        send_item(mk_item(sseg_pkg::OP_HALFSTEP, 1'b1, 7'd0));
        send_item(mk_item(sseg_pkg::OP_RESET, 1'b1, 7'd50));
        for (i = 0; i < 16; i++)
        begin
            send_item(mk_item(sseg_pkg::OP_SEGMENT, i != 15,
                              (i == 0) ? 7'd0 : (i == 1) ? 7'd127 : 7'($urandom_range(0, 127))));
        end
        send_item(mk_item(sseg_pkg::OP_HALFSTEP, 1'b1, 7'd100));

        for (ph = 0; ph < 6; ph++)
        begin
            drain();
            case (ph)
                0: ;
                1:
                begin
                    write_reg(sseg_pkg::CFG_FIRST_STEP, 7'd0);
                    write_reg(sseg_pkg::CFG_SECOND_STEP, 7'd0);
                    write_reg(sseg_pkg::CFG_IDLE_DRIVE, 7'd0);
                    write_reg(CFG_UNUSED, 7'd127);
                end
                2:
                begin
                    write_reg(sseg_pkg::CFG_FIRST_STEP, 7'd100);
                    write_reg(sseg_pkg::CFG_SECOND_STEP, 7'd100);
                    write_reg(sseg_pkg::CFG_IDLE_DRIVE, 7'd127);
                    hold_req = 1'b1;
                end
                3:
                begin
                    write_reg(sseg_pkg::CFG_FIRST_STEP, 7'd127);
                    write_reg(sseg_pkg::CFG_SECOND_STEP, 7'd127);
                    write_reg(sseg_pkg::CFG_IDLE_DRIVE, 7'd85);
                end
                default:
                begin
                    write_reg(sseg_pkg::CFG_FIRST_STEP, 7'($urandom_range(0, 127)));
                    write_reg(sseg_pkg::CFG_SECOND_STEP, 7'($urandom_range(0, 127)));
                    write_reg(sseg_pkg::CFG_IDLE_DRIVE, 7'($urandom_range(0, 127)));
                    if (ph == 5)
                    begin
                        tx_idle_on = 1'b0;
                        rx_idle_on = 1'b0;
                    end
                end
            endcase
            cfg_valid <= 1'b0;
            target = active_items + 65;
            while (active_items < target)
            begin
                pick = $urandom_range(0, 99);
                if (!sb.ac_on && pick < 30)
                begin
                    send_item(mk_item(sseg_pkg::OP_START, 1'($urandom_range(0, 1)),
                                      rand_power()));
                end
                else if (pick < 72)
                begin
                    send_item(mk_item(sseg_pkg::OP_SEGMENT, $urandom_range(0, 9) != 0,
                                      rand_power()));
                    halves = ($urandom_range(0, 4) != 0) ? 2 : $urandom_range(0, 3);
                    repeat (halves)
                    begin
                        send_item(mk_item(sseg_pkg::OP_HALFSTEP, 1'($urandom_range(0, 1)),
                                          rand_power()));
                    end
                end
                else if (pick < 80)
                begin
                    send_item(mk_item(sseg_pkg::OP_START, 1'($urandom_range(0, 1)),
                                      rand_power()));
                end
                else if (pick < 86)
                begin
                    send_item(mk_item(sseg_pkg::OP_RESET, 1'($urandom_range(0, 1)),
                                      rand_power()));
                end
                else
                begin
                    send_item(mk_item(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                      7'($urandom_range(0, 127))));
                end
            end
        end
        drain();

        if (sb.errors == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
